// ===== hdl/csi_parameter_parser_macros.svh =====
// Assertion helpers shared by the blocks of the CSI parameter parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CSI_PARAMETER_PARSER_MACROS_SVH
`define CSI_PARAMETER_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/csi_pkg.sv =====
`timescale 1ns / 1ps

package csi_pkg;

  typedef enum logic {
    CTL_RUN,
    CTL_EMIT
  } ctl_state_t;

  // Event kinds on the result channel.
  localparam logic [1:0] EV_PARAM = 2'd0;
  localparam logic [1:0] EV_CTRL  = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_MARK_LO  = 8'h3C;  // '<'
  localparam logic [7:0] CH_MARK_HI  = 8'h3F;  // '?'
  localparam logic [7:0] CH_SEP      = 8'h3B;  // ';'
  localparam logic [7:0] CH_ZERO     = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE     = 8'h39;  // '9'
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_CTRL_END = 8'h20;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7F;

  localparam logic [19:0] RADIX   = 20'd10;
  localparam logic [15:0] ACC_MAX = 16'hFFFF;

  // Register index, taken from paddr[3] (registers are 8 bytes apart).
  localparam logic REG_DEFAULT_TABLE = 1'b0;

  typedef struct packed {
    logic take;   // accept the input request
    logic emit;   // load the next stored parameter into the output register
  } csi_cmd_t;

  typedef struct packed {
    logic final_hit;  // the presented byte closes a sequence with results
    logic emit_last;  // the parameter being emitted is the last one
    logic out_free;   // the output register can take a new request
  } csi_stat_t;

endpackage

// ===== hdl/csi_if.sv =====
`timescale 1ns / 1ps

interface csi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       start_sequence;

  modport source (output valid, byte_in, start_sequence, input ready);
  modport sink (input valid, byte_in, start_sequence, output ready);
endinterface

interface csi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  code_byte;
  logic [7:0]  private_prefix;
  logic [4:0]  param_index;
  logic [15:0] param_value;
  logic [5:0]  param_count;
  logic        last;

  modport source (output valid, event_kind, code_byte, private_prefix, param_index,
                  param_value, param_count, last, input ready);
  modport sink (input valid, event_kind, code_byte, private_prefix, param_index,
                param_value, param_count, last, output ready);
endinterface

// ===== hdl/csi_parameter_parser.sv =====
// CSI parameter parser: takes the bytes that follow ESC [ one request at a time and
// turns them into parameter, control pass-through and abort events. Every byte that
// produces no result or a single result is taken whenever the output register is
// free and no parameters are pending. A final byte 0x40..0x7F is taken and then holds
// the input off while its N stored parameters (N from 1 to MAX_PARAMS) leave the
// output register, one per cycle while the sink is ready.
// The 64-bit default table sits at byte address 0 of the APB port and resets to zero.
`timescale 1ns / 1ps
`include "csi_parameter_parser_macros.svh"

module csi_parameter_parser #(
  parameter int MAX_PARAMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  csi_in_if.sink      in_ch,
  csi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  csi_pkg::csi_cmd_t  cmd;
  csi_pkg::csi_stat_t stat;
  logic               cfg_we;
  logic [63:0]        cfg_table;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[3] == csi_pkg::REG_DEFAULT_TABLE);
  assign prdata = (paddr[3] == csi_pkg::REG_DEFAULT_TABLE) ? cfg_table : 64'd0;

  csi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  csi_dpath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .byte_in        (in_ch.byte_in),
    .start_sequence (in_ch.start_sequence),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata),
    .cfg_table      (cfg_table),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_kind       (out_ch.event_kind),
    .out_code       (out_ch.code_byte),
    .out_prefix     (out_ch.private_prefix),
    .out_index      (out_ch.param_index),
    .out_value      (out_ch.param_value),
    .out_count      (out_ch.param_count),
    .out_last       (out_ch.last)
  );

  `CSI_ASSERT_NEXT(a_final_holds_input, in_ch.valid && in_ch.ready && stat.final_hit, !in_ch.ready, "input taken while parameters are pending")
  `CSI_ASSERT_SAME(a_emit_alone, cmd.emit, !cmd.take && stat.out_free, "emit collided with input or a full output register")
  `CSI_ASSERT_SAME(a_single_event, out_ch.valid && out_ch.event_kind != csi_pkg::EV_PARAM, out_ch.last && out_ch.param_count == 6'd0, "single event malformed")

endmodule

// ===== hdl/csi_ctrl.sv =====
`timescale 1ns / 1ps

module csi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  csi_pkg::csi_stat_t  stat,
  output logic                in_ready,
  output csi_pkg::csi_cmd_t   cmd
);

  csi_pkg::ctl_state_t state_r;
  csi_pkg::ctl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csi_pkg::CTL_RUN: begin
        if (in_valid && stat.out_free && stat.final_hit) begin
          state_nxt = csi_pkg::CTL_EMIT;
        end
      end
      csi_pkg::CTL_EMIT: begin
        if (stat.out_free && stat.emit_last) begin
          state_nxt = csi_pkg::CTL_RUN;
        end
      end
      default: state_nxt = csi_pkg::CTL_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      csi_pkg::CTL_RUN: begin
        in_ready = stat.out_free;
        cmd.take = in_valid && stat.out_free;
      end
      csi_pkg::CTL_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csi_pkg::CTL_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/csi_dpath.sv =====
`timescale 1ns / 1ps

module csi_dpath #(
  parameter int MAX_PARAMS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  csi_pkg::csi_cmd_t   cmd,
  output csi_pkg::csi_stat_t  stat,
  input  logic [7:0]          byte_in,
  input  logic                start_sequence,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  output logic [63:0]         cfg_table,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_code,
  output logic [7:0]          out_prefix,
  output logic [4:0]          out_index,
  output logic [15:0]         out_value,
  output logic [5:0]          out_count,
  output logic                out_last
);

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARAMS);

  logic [63:0]   table_r, table_nxt;
  logic          phase_r, phase_nxt;
  logic [7:0]    marker_r, marker_nxt;
  logic          present_r, present_nxt;
  logic [15:0]   accum_r, accum_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] emit_idx_r, emit_idx_nxt;
  logic [7:0]    code_r, code_nxt;
  logic          def_r, def_nxt;
  logic [16:0]   store_r [MAX_PARAMS];

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_code_r, out_code_nxt;
  logic [7:0]    out_prefix_r, out_prefix_nxt;
  logic [4:0]    out_index_r, out_index_nxt;
  logic [15:0]   out_value_r, out_value_nxt;
  logic [5:0]    out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;

  // Byte classification.
  logic          active, is_marker, proc, is_low, is_digit, is_sep, is_esc, is_ctrl;
  logic          is_final, push, room, store_we;
  logic [CW-1:0] eff_count;
  logic          eff_present;
  logic [15:0]   eff_accum;
  logic [7:0]    digit;
  logic [19:0]   acc_sum;
  logic [15:0]   acc_sat;
  logic [16:0]   rd_entry_r;

  always_comb begin
    active    = start_sequence || phase_r;
    is_marker = start_sequence && (byte_in >= csi_pkg::CH_MARK_LO) &&
                (byte_in <= csi_pkg::CH_MARK_HI);
    proc      = active && !is_marker;
    is_low    = byte_in < csi_pkg::CH_FINAL_LO;
    is_digit  = (byte_in >= csi_pkg::CH_ZERO) && (byte_in <= csi_pkg::CH_NINE);
    is_sep    = byte_in == csi_pkg::CH_SEP;
    is_esc    = byte_in == csi_pkg::CH_ESC;
    is_ctrl   = (byte_in < csi_pkg::CH_CTRL_END) && !is_esc;
    is_final  = !is_low && (byte_in <= csi_pkg::CH_FINAL_HI);

    // A start byte sees the sequence state as freshly cleared.
    eff_count   = start_sequence ? '0 : count_r;
    eff_present = start_sequence ? 1'b0 : present_r;
    eff_accum   = start_sequence ? 16'd0 : accum_r;

    push = proc && (is_sep || is_final);
    room = eff_count < MAX_CNT;

    digit   = byte_in - csi_pkg::CH_ZERO;
    acc_sum = (20'(eff_accum) * csi_pkg::RADIX) + 20'(digit[3:0]);
    acc_sat = (acc_sum > 20'(csi_pkg::ACC_MAX)) ? csi_pkg::ACC_MAX : acc_sum[15:0];

    store_we = cmd.take && push && room;
  end

  always_comb begin
    stat.final_hit = proc && is_final;
    stat.emit_last = (CW'(emit_idx_r) + CW'(1)) == count_r;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    table_nxt      = cfg_we ? cfg_wdata : table_r;
    phase_nxt      = phase_r;
    marker_nxt     = marker_r;
    present_nxt    = present_r;
    accum_nxt      = accum_r;
    count_nxt      = count_r;
    emit_idx_nxt   = emit_idx_r;
    code_nxt       = code_r;
    def_nxt        = def_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_code_nxt   = out_code_r;
    out_prefix_nxt = out_prefix_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (cmd.take) begin
      phase_nxt   = active && !(proc && (is_esc || !is_low));
      present_nxt = eff_present;
      accum_nxt   = eff_accum;
      count_nxt   = eff_count;
      if (start_sequence) begin
        marker_nxt = is_marker ? byte_in : 8'd0;
      end
      if (proc && is_low && is_digit) begin
        accum_nxt   = acc_sat;
        present_nxt = 1'b1;
      end
      if (push) begin
        present_nxt = 1'b0;
        accum_nxt   = 16'd0;
        if (room) begin
          count_nxt = eff_count + CW'(1);
        end
      end
      if (proc && is_final) begin
        code_nxt     = byte_in;
        // Final bytes 0x40..0x7F index the table with their low six bits.
        def_nxt      = table_r[byte_in[5:0]];
        emit_idx_nxt = '0;
      end
      if (proc && is_low && (is_esc || is_ctrl)) begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = is_esc ? csi_pkg::EV_ABORT : csi_pkg::EV_CTRL;
        out_code_nxt   = byte_in;
        out_prefix_nxt = 8'd0;
        out_index_nxt  = 5'd0;
        out_value_nxt  = 16'd0;
        out_count_nxt  = 6'd0;
        out_last_nxt   = 1'b1;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = csi_pkg::EV_PARAM;
      out_code_nxt   = code_r;
      out_prefix_nxt = marker_r;
      out_index_nxt  = 5'(emit_idx_r);
      out_value_nxt  = rd_entry_r[16] ? rd_entry_r[15:0] : {15'd0, def_r};
      out_count_nxt  = 6'(count_r);
      out_last_nxt   = stat.emit_last;
      emit_idx_nxt   = emit_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r     <= 64'd0;
      phase_r     <= 1'b0;
      marker_r    <= 8'd0;
      present_r   <= 1'b0;
      accum_r     <= 16'd0;
      count_r     <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      table_r     <= table_nxt;
      phase_r     <= phase_nxt;
      marker_r    <= marker_nxt;
      present_r   <= present_nxt;
      accum_r     <= accum_nxt;
      count_r     <= count_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    def_r        <= def_nxt;
    out_kind_r   <= out_kind_nxt;
    out_code_r   <= out_code_nxt;
    out_prefix_r <= out_prefix_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    if (store_we) begin
      store_r[eff_count[IW-1:0]] <= {eff_present, eff_accum};
    end
    // The read port fetches the entry to be emitted next. A write to that same
    // entry in this cycle is forwarded so the read sees the new parameter.
    if (store_we && (eff_count[IW-1:0] == emit_idx_nxt)) begin
      rd_entry_r <= {eff_present, eff_accum};
    end else begin
      rd_entry_r <= store_r[emit_idx_nxt];
    end
  end

  assign cfg_table  = table_r;
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_code   = out_code_r;
  assign out_prefix = out_prefix_r;
  assign out_index  = out_index_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

// ===== bench/csi_parameter_parser_tb.sv =====
`timescale 1ns / 1ps

module csi_parameter_parser_tb;

  localparam int MAX_PARAMS    = 16;
  localparam int IDX_W         = $clog2(MAX_PARAMS);
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [3:0] TABLE_ADDR = {csi_pkg::REG_DEFAULT_TABLE, 3'b000};

  typedef struct {
    logic [7:0] value;
    logic       start;
    bit         drain_first;
  } stream_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [7:0]  prefix;
    logic [4:0]  index;
    logic [15:0] value;
    logic [5:0]  count;
    logic        last;
  } csi_event_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  csi_in_if  in_bus ();
  csi_out_if out_bus ();

  csi_parameter_parser #(
    .MAX_PARAMS(MAX_PARAMS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Parser state mirrored by the bench.
  logic [63:0] default_table_model;
  logic        seq_active;
  logic [7:0]  seq_marker;
  logic        seq_present;
  logic [15:0] seq_accum;
  logic [5:0]  seq_count;
  logic [16:0] seq_store [MAX_PARAMS];

  stream_byte_t pending_bytes[$];
  csi_event_t   expected_events[$];

  int  error_count = 0;
  int  bytes_queued = 0;
  int  bytes_accepted = 0;
  int  events_checked = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  bit  sender_idle_en = 1;
  bit  recv_idle_en = 1;
  bit  drain_mode = 0;
  bit  drain_next = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void emit_event(logic [1:0] kind, logic [7:0] code, logic [7:0] prefix,
                                     logic [4:0] index, logic [15:0] value, logic [5:0] count,
                                     logic last);
    csi_event_t ev;
    ev = '{kind: kind, code: code, prefix: prefix, index: index, value: value,
           count: count, last: last};
    expected_events.push_back(ev);
  endfunction

  function automatic void store_param();
    if (seq_count < MAX_PARAMS) begin
      seq_store[IDX_W'(seq_count)] = {seq_present, seq_accum};
      seq_count++;
    end
    seq_present = 1'b0;
    seq_accum = '0;
  endfunction

  function automatic void parse_byte(logic [7:0] ch, logic start);
    logic [19:0] grown;
    logic        dflt;
    logic [16:0] entry;
    if (start) begin
      seq_marker = '0;
      seq_present = 1'b0;
      seq_accum = '0;
      seq_count = '0;
      seq_active = 1'b1;
      if (ch >= csi_pkg::CH_MARK_LO && ch <= csi_pkg::CH_MARK_HI) begin
        seq_marker = ch;
        return;
      end
    end else if (!seq_active) begin
      return;
    end
    if (ch < csi_pkg::CH_FINAL_LO) begin
      if (ch >= csi_pkg::CH_ZERO && ch <= csi_pkg::CH_NINE) begin
        grown = 20'(seq_accum) * csi_pkg::RADIX + 20'(ch - csi_pkg::CH_ZERO);
        seq_accum = (grown > 20'(csi_pkg::ACC_MAX)) ? csi_pkg::ACC_MAX : grown[15:0];
        seq_present = 1'b1;
      end else if (ch == csi_pkg::CH_SEP) begin
        store_param();
      end else if (ch == csi_pkg::CH_ESC) begin
        seq_active = 1'b0;
        emit_event(csi_pkg::EV_ABORT, csi_pkg::CH_ESC, '0, '0, '0, '0, 1'b1);
      end else if (ch < csi_pkg::CH_CTRL_END) begin
        emit_event(csi_pkg::EV_CTRL, ch, '0, '0, '0, '0, 1'b1);
      end
      return;
    end
    seq_active = 1'b0;
    if (ch > csi_pkg::CH_FINAL_HI) return;
    store_param();
    dflt = default_table_model[6'(ch - csi_pkg::CH_FINAL_LO)];
    for (int p = 0; p < seq_count; p++) begin
      entry = seq_store[IDX_W'(p)];
      emit_event(csi_pkg::EV_PARAM, ch, seq_marker, 5'(p),
                 entry[16] ? entry[15:0] : {15'd0, dflt},
                 seq_count, (p + 1 == seq_count));
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void queue_byte(logic [7:0] ch, logic start);
    stream_byte_t item;
    item = '{value: ch, start: start, drain_first: drain_next};
    drain_next = 0;
    pending_bytes.push_back(item);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] control_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, csi_pkg::CH_CTRL_END - 1)); while (ch == csi_pkg::CH_ESC);
    return ch;
  endfunction

  function automatic logic [7:0] stray_byte();
    case ($urandom_range(0, 2))
      0: return control_byte();
      1: return 8'($urandom_range(8'h20, 8'h2F));
      default: return 8'($urandom_range(8'h3A, csi_pkg::CH_MARK_HI));
    endcase
  endfunction

  // One well-formed sequence with random content; the closing byte may be missing,
  // in which case the next start flag restarts the parser.
  function automatic void add_sequence();
    bit         first;
    int         n;
    int         digits;
    int         r;
    logic [7:0] closer;
    first = 1;
    if ($urandom_range(0, 3) == 0) begin
      queue_byte(8'($urandom_range(csi_pkg::CH_MARK_LO, csi_pkg::CH_MARK_HI)), 1'b1);
      first = 0;
    end
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        queue_byte(csi_pkg::CH_SEP, first);
        first = 0;
      end
      digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
      for (int d = 0; d < digits; d++) begin
        queue_byte(8'(csi_pkg::CH_ZERO + $urandom_range(0, 9)), first);
        first = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        queue_byte(stray_byte(), first);
        first = 0;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 80) closer = 8'($urandom_range(csi_pkg::CH_FINAL_LO, csi_pkg::CH_FINAL_HI));
    else if (r < 87) closer = csi_pkg::CH_ESC;
    else if (r < 94) closer = 8'($urandom_range(8'h80, 8'hFF));
    else return;
    queue_byte(closer, first);
  endfunction

  function automatic void add_random(int target);
    int base;
    base = bytes_queued;
    while (bytes_queued - base < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else begin
        if (drain_mode && $urandom_range(0, 5) == 0) drain_next = 1;
        add_sequence();
      end
    end
  endfunction

  task automatic apb_access(input logic wr, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= TABLE_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_table(input logic [63:0] value);
    logic [63:0] rd;
    apb_access(1'b1, value, rd);
    default_table_model = value;
    apb_access(1'b0, '0, rd);
    check_field("default_table readback", value[31:0], rd[31:0]);
    check_field("default_table readback high", value[63:32], rd[63:32]);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_byte(in_bus.byte_in, in_bus.start_sequence);
        void'(pending_bytes.pop_front());
        bytes_accepted++;
        send_gap = pick_gap(sender_idle_en);
      end
      if (in_bus.valid && !in_bus.ready) begin
        // The offered request stays on the bus until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain_first && expected_events.size() != 0)) begin
        in_bus.valid <= 1'b1;
        in_bus.byte_in <= pending_bytes[0].value;
        in_bus.start_sequence <= pending_bytes[0].start;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap(recv_idle_en);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    csi_event_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      events_checked++;
      kind_seen[out_bus.event_kind]++;
      if (expected_events.size() == 0) begin
        $error("unexpected result: kind %0d code 0x%0h", out_bus.event_kind,
               out_bus.code_byte);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", want.kind, out_bus.event_kind);
        check_field("code_byte", want.code, out_bus.code_byte);
        check_field("private_prefix", want.prefix, out_bus.private_prefix);
        check_field("param_index", want.index, out_bus.param_index);
        check_field("param_value", want.value, out_bus.param_value);
        check_field("param_count", want.count, out_bus.param_count);
        check_field("last", want.last, out_bus.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.byte_in = '0;
    in_bus.start_sequence = 1'b0;
    out_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    default_table_model = '0;
    seq_active = 1'b0;
    seq_marker = '0;
    seq_present = 1'b0;
    seq_accum = '0;
    seq_count = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the default table still at its reset value.
    queue_byte("A", 1'b0);               // idle byte, ignored
    queue_byte("?", 1'b1);               // private marker
    queue_byte("1", 1'b0);
    queue_byte(csi_pkg::CH_SEP, 1'b0);
    queue_byte(csi_pkg::CH_SEP, 1'b0);   // empty parameter
    queue_byte("7", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte("0", 1'b0);               // 70000 saturates
    queue_byte("=", 1'b0);               // late marker is ignored
    queue_byte(8'h08, 1'b0);             // backspace passes through
    queue_byte(8'h1F, 1'b0);
    queue_byte("m", 1'b0);
    queue_byte("5", 1'b1);
    queue_byte(csi_pkg::CH_ESC, 1'b0);   // abort
    queue_byte("7", 1'b1);
    queue_byte("H", 1'b1);               // restart drops the pending digit
    queue_byte(8'hFF, 1'b1);             // high final, silent
    queue_byte("A", 1'b0);
    queue_byte("<", 1'b1);
    queue_byte(csi_pkg::CH_FINAL_HI, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(csi_pkg::CH_FINAL_LO, 1'b0);
    wait_drained();

    apply_table('1);
    sender_idle_en = 0;
    recv_idle_en = 0;
    add_random(60);
    wait_drained();

    // The receiver holds off while the sender keeps offering requests.
    apply_table({$urandom, $urandom});
    recv_idle_en = 1;
    hold_requests++;
    add_random(60);
    wait_drained();

    apply_table({$urandom, $urandom});
    sender_idle_en = 1;
    drain_mode = 1;
    add_random(80);
    wait_drained();

    apply_table('0);
    drain_mode = 0;
    add_random(65);
    wait_drained();

    $display("Sent %0d bytes and checked %0d results: %0d parameters, %0d controls, %0d aborts.",
             bytes_accepted, events_checked, kind_seen[csi_pkg::EV_PARAM],
             kind_seen[csi_pkg::EV_CTRL], kind_seen[csi_pkg::EV_ABORT]);
    $display("Default tables covered zeros, ones and random patterns, with stalls and drains.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
